// ===== rtl/ppnc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, fixed-point constants and helper functions for the paraboloid
// point, normal and curvature core. No dependencies.
package ppnc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CQ        = 30;
	localparam int STEPS     = 30;
	localparam int ZW        = 34;
	localparam int CW        = 34;
	localparam int VW        = 57;
	localparam int RW        = 36;

	localparam logic signed [RW-1:0] PI_Q      = 36'sd3373259426;
	localparam logic signed [RW-1:0] HALF_PI_Q = 36'sd1686629713;
	localparam logic signed [RW-1:0] TWO_PI_Q  = 36'sd6746518852;
	localparam logic signed [CW-1:0] GAIN_Q    = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q     = 34'sd1073741824;

	typedef logic [19:0] coeff_t;

	typedef struct packed {
		logic signed [31:0] radius_param;
		logic signed [19:0] angle_param;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] gauss_curv;
		logic signed [31:0] mean_curv;
		logic signed [31:0] curv_meridian;
		logic signed [31:0] curv_parallel;
		logic               overflow_flag;
	} out_item_t;

	// Fields that ride alongside the angle rotation.
	typedef struct packed {
		logic signed [31:0] u;
		coeff_t             a;
		logic               neg;
		logic [31:0]        zr;
		logic               zflag;
	} side_a_t;

	// Fields that ride alongside the normal rotation.
	typedef struct packed {
		side_a_t             sa;
		logic signed [CW-1:0] cv;
		logic signed [CW-1:0] sv;
		logic                tz;
	} side_b_t;

	typedef struct packed {
		logic signed [ZW-1:0] r;
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic                 tz;
		side_a_t              sa;
	} front_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               ovf;
	} sat_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = ZW'(64'sd1 <<< (CQ - i));
		endcase
		return r;
	endfunction

	// Round half up, then drop s fraction bits.
	function automatic logic signed [63:0] rnd_s(input logic signed [63:0] x, input int s);
		logic signed [63:0] r;
		r = (x + (64'sd1 <<< (s - 1))) >>> s;
		return r;
	endfunction

	function automatic sat_t sat32(input logic signed [63:0] x);
		sat_t r;
		r.ovf = 1'b0;
		r.val = x[31:0];
		if (x > 64'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'sh7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'sh80000000;
		end
		return r;
	endfunction

endpackage

// ===== rtl/ppnc_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of type T per request.
// Depends on nothing; payload types come from ppnc_pkg at the instance.
interface ppnc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ppnc_cordic.sv =====
`timescale 1ns / 1ps
// Fully pipelined CORDIC, one micro-rotation per stage, rotation or vectoring.
// Depends on ppnc_pkg for the arctangent table and step count.
module ppnc_cordic #(
	parameter bit  VECTOR_MODE = 1'b0,
	parameter int  W           = 34,
	parameter type side_t      = logic
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic signed [W-1:0]           x_in,
	input  logic signed [W-1:0]           y_in,
	input  logic signed [ppnc_pkg::ZW-1:0] z_in,
	input  side_t                         side_in,
	output logic                          out_vld,
	output logic signed [W-1:0]           x_out,
	output logic signed [W-1:0]           y_out,
	output logic signed [ppnc_pkg::ZW-1:0] z_out,
	output side_t                         side_out
);
	import ppnc_pkg::*;

	logic                 vld_s  [STEPS];
	logic signed [W-1:0]  x_s    [STEPS];
	logic signed [W-1:0]  y_s    [STEPS];
	logic signed [ZW-1:0] z_s    [STEPS];
	side_t                side_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic                 vp;
		logic signed [W-1:0]  xp;
		logic signed [W-1:0]  yp;
		logic signed [ZW-1:0] zp;
		side_t                sp;
		logic                 pos;

		if (i == 0) begin : g_first
			assign vp = in_vld;
			assign xp = x_in;
			assign yp = y_in;
			assign zp = z_in;
			assign sp = side_in;
		end else begin : g_next
			assign vp = vld_s[i-1];
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign sp = side_s[i-1];
		end

		// Rotation drives z toward zero, vectoring drives y toward zero.
		assign pos = VECTOR_MODE ? (yp <= 0) : (zp >= 0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i] <= sp;
				if (pos) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_step(i);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_step(i);
				end
			end
		end
	end

	assign out_vld  = vld_s[STEPS-1];
	assign x_out    = x_s[STEPS-1];
	assign y_out    = y_s[STEPS-1];
	assign z_out    = z_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

endmodule

// ===== rtl/ppnc_front.sv =====
`timescale 1ns / 1ps
// Six-stage front end: angle reduction, height a*u^2 and normalization of
// (1, 2au) for the vectoring CORDIC. Depends on ppnc_pkg.
module ppnc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  ppnc_pkg::in_item_t item,
	input  ppnc_pkg::coeff_t   coeff,
	output logic               out_vld,
	output ppnc_pkg::front_t   res
);
	import ppnc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [31:0]   u_s1, u_s2, u_s3, u_s4, u_s5;
	logic signed [19:0]   v_s1;
	coeff_t               a_s1, a_s2, a_s3, a_s4, a_s5;
	logic [31:0]          au_s2;
	logic signed [RW-1:0] r_s2, r_s3;
	logic [52:0]          t_s3, t_s4;
	logic [63:0]          sq_s3;
	logic [46:0]          u2_s4;
	logic [4:0]           k_s4;
	logic signed [ZW-1:0] r_s4, r_s5;
	logic                 neg_s4, neg_s5;
	logic [66:0]          zp_s5;
	logic signed [VW-1:0] x_s5, y_s5;
	logic                 tz_s5;
	front_t               res_s6;

	logic [31:0]          au_c;
	logic signed [RW-1:0] rv_c, rw_c, ra_c, rf_c;
	logic                 neg_c;
	logic [4:0]           k_c;
	logic [51:0]          zs_c;

	always_comb begin
		au_c = u_s1[31] ? (~u_s1 + 32'd1) : u_s1;
		rv_c = {{2{v_s1[19]}}, v_s1, 14'b0};
		rw_c = rv_c;
		if (rv_c >= TWO_PI_Q) begin
			rw_c = rv_c - TWO_PI_Q;
		end else if (rv_c <= -TWO_PI_Q) begin
			rw_c = rv_c + TWO_PI_Q;
		end
	end

	always_comb begin
		ra_c = r_s2;
		if (r_s2 > PI_Q) begin
			ra_c = r_s2 - TWO_PI_Q;
		end else if (r_s2 < -PI_Q) begin
			ra_c = r_s2 + TWO_PI_Q;
		end
	end

	// Fold into the right half plane; the sign flip is applied after rotation.
	always_comb begin
		rf_c  = r_s3;
		neg_c = 1'b0;
		if (r_s3 > HALF_PI_Q) begin
			rf_c  = r_s3 - PI_Q;
			neg_c = 1'b1;
		end else if (r_s3 < -HALF_PI_Q) begin
			rf_c  = r_s3 + PI_Q;
			neg_c = 1'b1;
		end
	end

	// Shift count that lifts (2^32, t) until either reaches 2^50.
	always_comb begin
		k_c = 5'd18;
		for (int j = 32; j < 50; j++) begin
			if (t_s3[j]) begin
				k_c = 5'(50 - j);
			end
		end
		if (|t_s3[52:50]) begin
			k_c = 5'd0;
		end
	end

	assign zs_c = 52'(zp_s5 >> FRAC_BITS) + 52'(zp_s5[FRAC_BITS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= item.radius_param;
			v_s1 <= item.angle_param;
			a_s1 <= coeff;

			u_s2  <= u_s1;
			a_s2  <= a_s1;
			au_s2 <= au_c;
			r_s2  <= rw_c;

			u_s3  <= u_s2;
			a_s3  <= a_s2;
			t_s3  <= 53'({a_s2, 1'b0}) * 53'(au_s2);
			sq_s3 <= 64'(au_s2) * 64'(au_s2);
			r_s3  <= ra_c;

			u_s4   <= u_s3;
			a_s4   <= a_s3;
			t_s4   <= t_s3;
			u2_s4  <= 47'(sq_s3 >> FRAC_BITS) + 47'(sq_s3[FRAC_BITS-1]);
			k_s4   <= k_c;
			r_s4   <= ZW'(rf_c);
			neg_s4 <= neg_c;

			u_s5   <= u_s4;
			a_s5   <= a_s4;
			r_s5   <= r_s4;
			neg_s5 <= neg_s4;
			zp_s5  <= 67'(u2_s4) * 67'(a_s4);
			x_s5   <= (VW'(1) << 32) << k_s4;
			y_s5   <= VW'(t_s4) << k_s4;
			tz_s5  <= (t_s4 == '0);

			res_s6.r        <= r_s5;
			res_s6.x        <= x_s5;
			res_s6.y        <= y_s5;
			res_s6.tz       <= tz_s5;
			res_s6.sa.u     <= u_s5;
			res_s6.sa.a     <= a_s5;
			res_s6.sa.neg   <= neg_s5;
			if (zs_c > 52'h7FFFFFFF) begin
				res_s6.sa.zr    <= 32'h7FFFFFFF;
				res_s6.sa.zflag <= 1'b1;
			end else begin
				res_s6.sa.zr    <= zs_c[31:0];
				res_s6.sa.zflag <= 1'b0;
			end
		end
	end

	assign out_vld = vld_s6;
	assign res     = res_s6;

endmodule

// ===== rtl/ppnc_tail.sv =====
`timescale 1ns / 1ps
// Seven-stage back end: clamping, products, rounding and saturation of the
// point, normal and curvatures. The last stage is the output register. Uses ppnc_pkg.
module ppnc_tail (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic signed [ppnc_pkg::CW-1:0] q_in,
	input  logic signed [ppnc_pkg::CW-1:0] p_in,
	input  ppnc_pkg::side_b_t           side,
	output logic                        out_vld,
	output ppnc_pkg::out_item_t         res
);
	import ppnc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [31:0] cv_s1, sv_s1, q_s1, np_s1, u_s1;
	coeff_t             a_s1, a_s2, a_s3, a_s4, a_s5;
	logic [31:0]        zr_s1, zr_s2, zr_s3, zr_s4, zr_s5, zr_s6;
	logic               zf_s1, zf_s2, zf_s3;

	logic signed [63:0] px_s2, py_s2, nxp_s2, nyp_s2, q2p_s2;
	logic signed [31:0] q_s2, q_s3, q_s4, q_s5;

	logic signed [31:0] px_s3, py_s3, nx_s3, ny_s3, nz_s3, q2_s3;
	logic               fxy_s3;

	logic signed [31:0] px_s4, py_s4, nx_s4, ny_s4, nz_s4;
	logic               fl_s4, fl_s5, fl_s6;
	logic signed [63:0] q3p_s4, aq2_s4;

	logic signed [31:0] px_s5, py_s5, nx_s5, ny_s5, nz_s5, q3_s5;
	logic signed [32:0] hs_s5;
	logic [32:0]        pr_s5;

	logic signed [31:0] px_s6, py_s6, nx_s6, ny_s6, nz_s6;
	logic [65:0]        kp_s6;
	logic signed [63:0] hp_s6, k1p_s6, k2p_s6;

	out_item_t          res_s7;

	logic signed [CW-1:0] cvn_c, svn_c, cvc_c, svc_c, qc_c, pc_c;
	sat_t                 sx_c, sy_c, sh_c, s1_c, s2_c;
	logic [32:0]          kr_c;
	logic signed [21:0]   a2_s3, a2_s5;
	logic signed [20:0]   as_s5;

	always_comb begin
		cvn_c = side.sa.neg ? -side.cv : side.cv;
		svn_c = side.sa.neg ? -side.sv : side.sv;
		cvc_c = (cvn_c > ONE_Q) ? ONE_Q : ((cvn_c < -ONE_Q) ? -ONE_Q : cvn_c);
		svc_c = (svn_c > ONE_Q) ? ONE_Q : ((svn_c < -ONE_Q) ? -ONE_Q : svn_c);
		// A zero radius gives the exact vertical normal.
		if (side.tz) begin
			qc_c = ONE_Q;
			pc_c = '0;
		end else begin
			qc_c = (q_in < 0) ? '0 : ((q_in > ONE_Q) ? ONE_Q : q_in);
			pc_c = (p_in < 0) ? '0 : ((p_in > ONE_Q) ? ONE_Q : p_in);
		end
	end

	assign sx_c  = sat32(rnd_s(px_s2, CQ));
	assign sy_c  = sat32(rnd_s(py_s2, CQ));
	assign a2_s3 = signed'({1'b0, a_s3, 1'b0});
	assign a2_s5 = signed'({1'b0, a_s5, 1'b0});
	assign as_s5 = signed'({1'b0, a_s5});
	assign kr_c  = 33'(kp_s6 >> (FRAC_BITS + 22)) + 33'(kp_s6[FRAC_BITS+21]);
	assign sh_c  = sat32(rnd_s(hp_s6, CQ));
	assign s1_c  = sat32(rnd_s(k1p_s6, CQ));
	assign s2_c  = sat32(rnd_s(k2p_s6, CQ));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cv_s1 <= 32'(cvc_c);
			sv_s1 <= 32'(svc_c);
			q_s1  <= 32'(qc_c);
			np_s1 <= side.sa.u[31] ? 32'(pc_c) : 32'(-pc_c);
			u_s1  <= side.sa.u;
			a_s1  <= side.sa.a;
			zr_s1 <= side.sa.zr;
			zf_s1 <= side.sa.zflag;

			px_s2  <= u_s1 * cv_s1;
			py_s2  <= u_s1 * sv_s1;
			nxp_s2 <= np_s1 * cv_s1;
			nyp_s2 <= np_s1 * sv_s1;
			q2p_s2 <= q_s1 * q_s1;
			q_s2   <= q_s1;
			a_s2   <= a_s1;
			zr_s2  <= zr_s1;
			zf_s2  <= zf_s1;

			px_s3  <= sx_c.val;
			py_s3  <= sy_c.val;
			fxy_s3 <= sx_c.ovf | sy_c.ovf;
			nx_s3  <= 32'(rnd_s(nxp_s2, 2 * CQ - FRAC_BITS));
			ny_s3  <= 32'(rnd_s(nyp_s2, 2 * CQ - FRAC_BITS));
			nz_s3  <= 32'(rnd_s(64'(q_s2), CQ - FRAC_BITS));
			q2_s3  <= 32'(rnd_s(q2p_s2, CQ));
			q_s3   <= q_s2;
			a_s3   <= a_s2;
			zr_s3  <= zr_s2;
			zf_s3  <= zf_s2;

			q3p_s4 <= q2_s3 * q_s3;
			aq2_s4 <= a2_s3 * q2_s3;
			q_s4   <= q_s3;
			a_s4   <= a_s3;
			zr_s4  <= zr_s3;
			fl_s4  <= zf_s3 | fxy_s3;
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			nz_s4  <= nz_s3;

			q3_s5 <= 32'(rnd_s(q3p_s4, CQ));
			hs_s5 <= 33'(q_s4) + 33'(rnd_s(q3p_s4, CQ));
			pr_s5 <= 33'(aq2_s4 >> 19) + 33'(aq2_s4[18]);
			q_s5  <= q_s4;
			a_s5  <= a_s4;
			zr_s5 <= zr_s4;
			fl_s5 <= fl_s4;
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
			nz_s5 <= nz_s4;

			kp_s6  <= 66'(pr_s5) * 66'(pr_s5);
			hp_s6  <= as_s5 * hs_s5;
			k1p_s6 <= a2_s5 * q3_s5;
			k2p_s6 <= a2_s5 * q_s5;
			zr_s6  <= zr_s5;
			fl_s6  <= fl_s5;
			px_s6  <= px_s5;
			py_s6  <= py_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			nz_s6  <= nz_s5;

			res_s7.pos_x         <= px_s6;
			res_s7.pos_y         <= py_s6;
			res_s7.pos_z         <= signed'(zr_s6);
			res_s7.normal_x      <= nx_s6;
			res_s7.normal_y      <= ny_s6;
			res_s7.normal_z      <= nz_s6;
			res_s7.gauss_curv    <= (kr_c > 33'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(kr_c[31:0]);
			res_s7.mean_curv     <= sh_c.val;
			res_s7.curv_meridian <= s1_c.val;
			res_s7.curv_parallel <= s2_c.val;
			res_s7.overflow_flag <= fl_s6 | (kr_c > 33'h7FFFFFFF) | sh_c.ovf
				| s1_c.ovf | s2_c.ovf;
		end
	end

	assign out_vld = vld_s7;
	assign res     = res_s7;

endmodule

// ===== rtl/paraboloid_point_normal_curvature_core.sv =====
`timescale 1ns / 1ps
// Paraboloid point, unit normal and curvatures, one request per cycle.
// The pipe holds 6 front-end stages, two 30-stage CORDIC pipelines in
// series (angle rotation runs beside the vectoring pass) and 7 back-end stages.
// Throughput is one request per clock; a stalled output holds the whole pipe.
// Reset clears all valid bits and loads the shape coefficient with 1.0.
module paraboloid_point_normal_curvature_core (
	input  logic           clk,
	input  logic           arst_n,
	ppnc_stream_if.sink    params,
	ppnc_stream_if.source  result,
	ppnc_stream_if.sink    cfg
);
	import ppnc_pkg::*;

	coeff_t               shape_q;
	logic                 adv;
	logic                 fr_vld, va_vld, vv_vld, vb_vld, tail_vld;
	front_t               fr;
	logic signed [CW-1:0] cv, sv, q, p;
	logic signed [ZW-1:0] ang;
	side_a_t              sa;
	logic                 vtz;
	side_b_t              sb_in, sb_out;
	out_item_t            res;

	assign cfg.ready    = 1'b1;
	assign adv          = !tail_vld || result.ready;
	assign params.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= 20'd65536;
		end else if (cfg.valid) begin
			shape_q <= cfg.data;
		end
	end

	ppnc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (params.valid),
		.item    (params.data),
		.coeff   (shape_q),
		.out_vld (fr_vld),
		.res     (fr)
	);

	ppnc_cordic #(.VECTOR_MODE(1'b0), .W(CW), .side_t(side_a_t)) u_rot_angle (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.x_in     (GAIN_Q),
		.y_in     ('0),
		.z_in     (fr.r),
		.side_in  (fr.sa),
		.out_vld  (va_vld),
		.x_out    (cv),
		.y_out    (sv),
		.z_out    (),
		.side_out (sa)
	);

	ppnc_cordic #(.VECTOR_MODE(1'b1), .W(VW), .side_t(logic)) u_vec_slope (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.x_in     (fr.x),
		.y_in     (fr.y),
		.z_in     ('0),
		.side_in  (fr.tz),
		.out_vld  (vv_vld),
		.x_out    (),
		.y_out    (),
		.z_out    (ang),
		.side_out (vtz)
	);

	always_comb begin
		sb_in.sa = sa;
		sb_in.cv = cv;
		sb_in.sv = sv;
		sb_in.tz = vtz;
	end

	ppnc_cordic #(.VECTOR_MODE(1'b0), .W(CW), .side_t(side_b_t)) u_rot_normal (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (va_vld & vv_vld),
		.x_in     (GAIN_Q),
		.y_in     ('0),
		.z_in     (ang),
		.side_in  (sb_in),
		.out_vld  (vb_vld),
		.x_out    (q),
		.y_out    (p),
		.z_out    (),
		.side_out (sb_out)
	);

	ppnc_tail u_tail (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vb_vld),
		.q_in    (q),
		.p_in    (p),
		.side    (sb_out),
		.out_vld (tail_vld),
		.res     (res)
	);

	assign result.valid = tail_vld;
	assign result.data  = res;

endmodule
